// ===== rtl/ukstk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ukstk_pkg
// Shared constants, codes and helpers for the unique key stack.
// ----------------------------------------------------------------------------
package ukstk_pkg;

	// storage geometry
	localparam int DEPTH   = 16;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int ENTRY_W = KEY_W + VAL_W;

	// field widths
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;
	localparam int IN_W     = 72;
	localparam int OUT_W    = 72;

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_DUP   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_UNDER = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_OVER  = 2'd3;

	// one result word before packing, highest bits first
	typedef struct packed {
		logic                is_empty;
		logic [COUNT_W-1:0]  entry_count;
		logic [VAL_W-1:0]    top_value;
		logic [KEY_W-1:0]    top_key;
		logic [STATUS_W-1:0] status;
	} result_t;

	// fill level to the reported count, low bits only
	function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] fill);
		logic [31:0] wide;
		wide = 32'(fill);
		return wide[COUNT_W-1:0];
	endfunction

endpackage

// ===== rtl/ukstk_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ukstk_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ukstk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/unique_key_stack_top.sv =====
`timescale 1ns / 1ps
// A push waits on the duplicate search, which reads one stored key per cycle from the
// RAM. A pop or peek does one RAM read of the top entry; underflow and the unused code
// make their result without a RAM read.
// One item is worked on at a time; the next word is accepted once the result is
// in the output register.
// Reset (arst_n low) empties the stack at once; the RAM contents are not cleared.
// ----------------------------------------------------------------------------
// unique_key_stack_top
// LIFO stack of key/value pairs held in a RAM, refusing pushes of keys
// already stored, with pop, peek and status reporting.
// ----------------------------------------------------------------------------
module unique_key_stack_top (
	input  logic                     clk,
	input  logic                     arst_n,
	// s_tdata: func[1:0], item_key[33:2], item_value[65:34], zero pad[71:66]
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [ukstk_pkg::IN_W-1:0]  s_tdata,
	// m_tdata: status[1:0], top_key[33:2], top_value[65:34],
	//          entry_count[70:66], is_empty[71]
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [ukstk_pkg::OUT_W-1:0] m_tdata
);

	import ukstk_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_READ,
		S_EMIT
	} state_t;

	state_t              state_q;
	logic [FUNC_W-1:0]   func_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    value_q;
	logic [CNT_W-1:0]    fill_q;
	logic [CNT_W-1:0]    rd_cnt_q;
	logic                cmp_vld_s1;
	result_t             res_q;
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	logic                in_fire;
	logic                out_free;
	logic                search_rd;
	logic                key_match;
	logic                ram_we;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0]  ram_rdata;
	logic [FUNC_W-1:0]   in_func;
	logic [KEY_W-1:0]    in_key;
	logic [VAL_W-1:0]    in_value;
	logic [CNT_W-1:0]    fill_dec;
	logic [CNT_W-1:0]    fill_inc;

	// whole result word from status, pair and fill level after the operation
	function automatic result_t make_result(input logic [STATUS_W-1:0] st,
			input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v,
			input logic [CNT_W-1:0] fill);
		result_t r;
		r.status      = st;
		r.top_key     = k;
		r.top_value   = v;
		r.entry_count = to_count(fill);
		r.is_empty    = (fill == '0);
		return r;
	endfunction

	// input word unpacking
	assign in_func  = s_tdata[FUNC_W-1:0];
	assign in_key   = s_tdata[FUNC_W +: KEY_W];
	assign in_value = s_tdata[FUNC_W + KEY_W +: VAL_W];

	// handshakes
	assign s_tready = (state_q == S_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// search reads one stored key per cycle
	assign search_rd = (state_q == S_SEARCH) && (rd_cnt_q < fill_q);
	assign key_match = cmp_vld_s1 && (ram_rdata[KEY_W-1:0] == key_q);
	assign fill_dec  = fill_q - CNT_W'(1);
	assign fill_inc  = fill_q + CNT_W'(1);

	// read port: search address, or top entry on pop and peek
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = rd_cnt_q[ADDR_W-1:0];
		if (search_rd) begin
			ram_re = 1'b1;
		end else if (in_fire && (in_func == FUNC_POP || in_func == FUNC_PEEK)) begin
			ram_re    = (fill_q != '0);
			ram_raddr = fill_dec[ADDR_W-1:0];
		end
	end

	// write the new top once the search finds no match and the stack is not full
	assign ram_we = (state_q == S_SEARCH) && !search_rd && !key_match &&
	                (fill_q < CNT_W'(DEPTH));

	ukstk_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[ADDR_W-1:0]),
		.wdata ({value_q, key_q}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output valid: set on emit, cleared when the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// control state machine and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			func_q     <= '0;
			key_q      <= '0;
			value_q    <= '0;
			fill_q     <= '0;
			rd_cnt_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			res_q      <= '0;
			m_tdata_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						func_q     <= in_func;
						key_q      <= in_key;
						value_q    <= in_value;
						rd_cnt_q   <= '0;
						cmp_vld_s1 <= 1'b0;
						if (in_func == FUNC_PUSH) begin
							state_q <= S_SEARCH;
						end else if (in_func == FUNC_POP || in_func == FUNC_PEEK) begin
							if (fill_q == '0) begin
								res_q   <= make_result(STAT_UNDER, '0, '0, fill_q);
								state_q <= S_EMIT;
							end else begin
								state_q <= S_READ;
							end
						end else begin
							// unused code: no change, zero pair
							res_q   <= make_result(STAT_OK, '0, '0, fill_q);
							state_q <= S_EMIT;
						end
					end
				end
				S_SEARCH: begin
					cmp_vld_s1 <= search_rd;
					if (search_rd) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end
					if (key_match) begin
						res_q   <= make_result(STAT_DUP, '0, '0, fill_q);
						state_q <= S_EMIT;
					end else if (!search_rd) begin
						if (fill_q < CNT_W'(DEPTH)) begin
							fill_q <= fill_inc;
							res_q  <= make_result(STAT_OK, '0, '0, fill_inc);
						end else begin
							res_q  <= make_result(STAT_OVER, '0, '0, fill_q);
						end
						state_q <= S_EMIT;
					end
				end
				S_READ: begin
					// top entry is on the read port now
					if (func_q == FUNC_POP) begin
						fill_q <= fill_dec;
						res_q  <= make_result(STAT_OK, ram_rdata[KEY_W-1:0],
							ram_rdata[ENTRY_W-1:KEY_W], fill_dec);
					end else begin
						res_q  <= make_result(STAT_OK, ram_rdata[KEY_W-1:0],
							ram_rdata[ENTRY_W-1:KEY_W], fill_q);
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						m_tdata_q <= res_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
